/* rtl/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, sizes, operation and fault codes of the stack machine.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int CALL_DEPTH  = 64;
  localparam int HEAP_DEPTH  = 4096;

  localparam int OP_W    = 5;
  localparam int IMM_W   = 8;
  localparam int HIDX_W  = 12;
  localparam int IP_W    = 16;
  localparam int FAULT_W = 3;

  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SCW  = $clog2(STACK_DEPTH + 1);
  localparam int RAW  = $clog2(CALL_DEPTH);
  localparam int RCW  = $clog2(CALL_DEPTH + 1);
  localparam int HAW  = $clog2(HEAP_DEPTH);
  localparam int SUMW = ((SCW > IMM_W) ? SCW : IMM_W) + 1;

  typedef logic [SCW-1:0]  sc_t;
  typedef logic [SAW-1:0]  saddr_t;
  typedef logic [RCW-1:0]  rc_t;
  typedef logic [RAW-1:0]  raddr_t;
  typedef logic [HAW-1:0]  haddr_t;
  typedef logic [SUMW-1:0] sum_t;
  typedef logic [IP_W-1:0] ip_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 5'd0,
    OP_HEAP_IMM  = 5'd1,
    OP_LOAD      = 5'd2,
    OP_CALL_TOP  = 5'd3,
    OP_RET       = 5'd4,
    OP_CALL_ABS  = 5'd5,
    OP_ADD_IMM   = 5'd6,
    OP_CMP_IMM   = 5'd7,
    OP_XOR_IMM   = 5'd8,
    OP_JMP       = 5'd9,
    OP_JE        = 5'd10,
    OP_JNE       = 5'd11,
    OP_CMP       = 5'd12,
    OP_EMIT      = 5'd13,
    OP_CALL_REL  = 5'd14,
    OP_HEAP_TOP  = 5'd15,
    OP_DROP      = 5'd16,
    OP_RAISE     = 5'd17,
    OP_ADD       = 5'd18,
    OP_SUB       = 5'd19,
    OP_XOR       = 5'd20,
    OP_MUL_IMM   = 5'd21,
    OP_MUL       = 5'd22
  } op_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE       = 3'd0,
    FAULT_UNDER      = 3'd1,
    FAULT_OVER       = 3'd2,
    FAULT_CALL_OVER  = 3'd3,
    FAULT_CALL_UNDER = 3'd4
  } fault_e;

  // Operand bytes that follow the operation byte
  function automatic logic [1:0] op_len(logic [OP_W-1:0] op);
    logic [1:0] len;
    case (op_e'(op))
      OP_PUSH, OP_CALL_ABS, OP_ADD_IMM, OP_CMP_IMM, OP_XOR_IMM, OP_JMP, OP_JE,
      OP_JNE, OP_CALL_REL, OP_DROP, OP_RAISE, OP_MUL_IMM: len = 2'd1;
      OP_LOAD, OP_HEAP_TOP:                              len = 2'd2;
      OP_HEAP_IMM:                                       len = 2'd3;
      default:                                           len = 2'd0;
    endcase
    return len;
  endfunction

  // Live stack entries an operation needs
  function automatic logic [1:0] op_need(logic [OP_W-1:0] op);
    logic [1:0] need;
    case (op_e'(op))
      OP_CALL_TOP, OP_ADD_IMM, OP_CMP_IMM, OP_XOR_IMM, OP_EMIT, OP_HEAP_TOP,
      OP_MUL_IMM:                           need = 2'd1;
      OP_CMP, OP_ADD, OP_SUB, OP_XOR, OP_MUL: need = 2'd2;
      default:                              need = 2'd0;
    endcase
    return need;
  endfunction

endpackage

/* rtl/svm_in_if.sv */
// ----------------------------------------------------------------------------
// svm_in_if
// Instruction channel: one decoded instruction per beat.
// ----------------------------------------------------------------------------
interface svm_in_if;
  logic                         valid;
  logic                         ready;
  logic [svm_pkg::OP_W-1:0]     operation;
  logic [svm_pkg::IMM_W-1:0]    immediate;
  logic [svm_pkg::HIDX_W-1:0]   heap_index;

  modport source (output valid, output operation, output immediate, output heap_index,
                  input ready);
  modport sink   (input valid, input operation, input immediate, input heap_index,
                  output ready);
endinterface

/* rtl/svm_out_if.sv */
// ----------------------------------------------------------------------------
// svm_out_if
// Result channel: one execution result per beat.
// ----------------------------------------------------------------------------
interface svm_out_if;
  logic                          valid;
  logic                          ready;
  logic [svm_pkg::IP_W-1:0]      next_ip;
  logic                          emit_valid;
  logic [svm_pkg::IMM_W-1:0]     emit_byte;
  logic                          compare_flag;
  logic [svm_pkg::FAULT_W-1:0]   fault;

  modport source (output valid, output next_ip, output emit_valid, output emit_byte,
                  output compare_flag, output fault, input ready);
  modport sink   (input valid, input next_ip, input emit_valid, input emit_byte,
                  input compare_flag, input fault, output ready);
endinterface

/* rtl/stack_vm_instruction_execute.sv */
// ----------------------------------------------------------------------------
// stack_vm_instruction_execute
// Executes decoded instructions of a byte-wide stack machine.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one decoded instruction per beat (operation, immediate,
//   heap_index); out_o returns one result per instruction (next_ip, emitted
//   byte, compare flag, fault code). Both are valid/ready channels.
//   The data stack, call stack and heap sit in RAMs with registered read
//   data. An instruction is accepted in the idle state, where its operand
//   reads are issued; the exec state computes, writes back and loads the
//   output register, waiting while a held result is not yet taken. Ready is
//   low in the exec state, so the next instruction is taken only after the
//   current one completes, set by the read-then-write round trip through the
//   stack RAM. After reset the heap is swept to zero, one entry a cycle, over
//   all HEAP_DEPTH (4096) entries; ready stays low during the sweep.
//   If the receiver stalls, the result holds in the output register; the
//   next instruction may still be accepted, but its write-back waits until
//   the held result is taken.
// ----------------------------------------------------------------------------
module stack_vm_instruction_execute (
  input  logic      clk_i,
  input  logic      rst_ni,
  svm_in_if.sink    in_i,
  svm_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  svm_pkg::haddr_t clr_q, clr_d;
  svm_pkg::ip_t    ip_q, ip_d;
  svm_pkg::sc_t    sc_q, sc_d;
  svm_pkg::rc_t    rc_q, rc_d;
  logic            flag_q, flag_d;

  logic [svm_pkg::OP_W-1:0]   op_q;
  logic [svm_pkg::IMM_W-1:0]  imm_q;
  logic [svm_pkg::HIDX_W-1:0] hidx_q;

  logic                          out_valid_q;
  svm_pkg::ip_t                  nip_q, nip_d;
  logic                          ev_q, ev_d;
  logic [svm_pkg::IMM_W-1:0]     eb_q, eb_d;
  logic                          oflag_q;
  svm_pkg::fault_e               fault_q, fault_d;

  logic advance;

  // RAM ports
  svm_pkg::saddr_t           top_addr, sec_addr, ds_waddr;
  logic [svm_pkg::IMM_W-1:0] top_rd, sec_rd, ds_wdata;
  logic                      ds_we;
  svm_pkg::raddr_t           rs_raddr, rs_waddr;
  svm_pkg::ip_t              rs_rd;
  logic                      rs_we;
  svm_pkg::haddr_t           hp_raddr, hp_waddr;
  logic [svm_pkg::IMM_W-1:0] hp_rd, hp_wdata, hp_val;
  logic                      hp_we, hp_exec_we, hp_in_range;

  logic [svm_pkg::IMM_W-1:0] mul_res, mul_opnd;
  logic [2*svm_pkg::IMM_W-1:0] mul_full;
  svm_pkg::sum_t             raise_sum;
  logic                      is_call;
  svm_pkg::ip_t              target;

  assign in_i.ready = (state_q == ST_IDLE);
  assign advance    = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);

  // Operand addresses follow the registered counts, so they hold while stalled
  assign top_addr = svm_pkg::saddr_t'(sc_q - svm_pkg::sc_t'(1));
  assign sec_addr = svm_pkg::saddr_t'(sc_q - svm_pkg::sc_t'(2));
  assign rs_raddr = svm_pkg::raddr_t'(rc_q - svm_pkg::rc_t'(1));
  assign rs_waddr = svm_pkg::raddr_t'(rc_q);
  assign hp_raddr = (state_q == ST_IDLE) ? svm_pkg::haddr_t'(in_i.heap_index)
                                         : svm_pkg::haddr_t'(hidx_q);

  assign hp_in_range = (32'(hidx_q) < 32'(svm_pkg::HEAP_DEPTH));
  assign hp_val      = hp_in_range ? hp_rd : '0;

  assign mul_opnd = (svm_pkg::op_e'(op_q) == svm_pkg::OP_MUL) ? sec_rd : imm_q;
  assign mul_full = (2*svm_pkg::IMM_W)'(top_rd) * (2*svm_pkg::IMM_W)'(mul_opnd);
  assign mul_res  = mul_full[svm_pkg::IMM_W-1:0];
  assign raise_sum = svm_pkg::sum_t'(sc_q) + svm_pkg::sum_t'(imm_q);

  always_comb begin
    nip_d      = ip_q + svm_pkg::ip_t'(svm_pkg::op_len(op_q)) + svm_pkg::ip_t'(1);
    fault_d    = svm_pkg::FAULT_NONE;
    ev_d       = 1'b0;
    eb_d       = '0;
    flag_d     = flag_q;
    sc_d       = sc_q;
    rc_d       = rc_q;
    ds_we      = 1'b0;
    ds_waddr   = top_addr;
    ds_wdata   = top_rd;
    hp_exec_we = 1'b0;
    hp_wdata   = imm_q;
    rs_we      = 1'b0;
    is_call    = 1'b0;
    target     = '0;

    if (sc_q < svm_pkg::sc_t'(svm_pkg::op_need(op_q))) begin
      fault_d = svm_pkg::FAULT_UNDER;
    end else begin
      case (svm_pkg::op_e'(op_q))
        svm_pkg::OP_PUSH, svm_pkg::OP_LOAD: begin
          if (sc_q == svm_pkg::sc_t'(svm_pkg::STACK_DEPTH)) begin
            fault_d = svm_pkg::FAULT_OVER;
          end else begin
            ds_we    = 1'b1;
            ds_waddr = svm_pkg::saddr_t'(sc_q);
            ds_wdata = (svm_pkg::op_e'(op_q) == svm_pkg::OP_LOAD) ? hp_val : imm_q;
            sc_d     = sc_q + svm_pkg::sc_t'(1);
          end
        end
        svm_pkg::OP_HEAP_IMM: begin
          hp_exec_we = hp_in_range;
        end
        svm_pkg::OP_HEAP_TOP: begin
          hp_exec_we = hp_in_range;
          hp_wdata   = top_rd;
        end
        svm_pkg::OP_CALL_TOP: begin
          is_call = 1'b1;
          target  = svm_pkg::ip_t'(top_rd);
        end
        svm_pkg::OP_CALL_ABS: begin
          is_call = 1'b1;
          target  = svm_pkg::ip_t'(imm_q);
        end
        svm_pkg::OP_CALL_REL: begin
          is_call = 1'b1;
          target  = ip_q + svm_pkg::ip_t'(2) + svm_pkg::ip_t'(imm_q);
        end
        svm_pkg::OP_RET: begin
          if (rc_q == '0) begin
            fault_d = svm_pkg::FAULT_CALL_UNDER;
          end else begin
            rc_d  = rc_q - svm_pkg::rc_t'(1);
            nip_d = rs_rd;
          end
        end
        svm_pkg::OP_ADD_IMM: begin
          ds_we    = 1'b1;
          ds_wdata = top_rd + imm_q;
        end
        svm_pkg::OP_CMP_IMM: begin
          flag_d = (top_rd == imm_q);
        end
        svm_pkg::OP_XOR_IMM: begin
          ds_we    = 1'b1;
          ds_wdata = top_rd ^ imm_q;
        end
        svm_pkg::OP_JMP: begin
          nip_d = svm_pkg::ip_t'(imm_q);
        end
        svm_pkg::OP_JE: begin
          if (flag_q) begin
            nip_d = svm_pkg::ip_t'(imm_q);
          end
        end
        svm_pkg::OP_JNE: begin
          if (!flag_q) begin
            nip_d = svm_pkg::ip_t'(imm_q);
          end
        end
        svm_pkg::OP_CMP: begin
          flag_d = (top_rd == sec_rd);
        end
        svm_pkg::OP_EMIT: begin
          ev_d = 1'b1;
          eb_d = top_rd;
        end
        svm_pkg::OP_DROP: begin
          if (svm_pkg::sum_t'(imm_q) > svm_pkg::sum_t'(sc_q)) begin
            fault_d = svm_pkg::FAULT_UNDER;
          end else begin
            sc_d = sc_q - svm_pkg::sc_t'(imm_q);
          end
        end
        svm_pkg::OP_RAISE: begin
          if (raise_sum > svm_pkg::sum_t'(svm_pkg::STACK_DEPTH)) begin
            fault_d = svm_pkg::FAULT_OVER;
          end else begin
            sc_d = svm_pkg::sc_t'(raise_sum);
          end
        end
        svm_pkg::OP_ADD: begin
          ds_we    = 1'b1;
          ds_wdata = top_rd + sec_rd;
        end
        svm_pkg::OP_SUB: begin
          ds_we    = 1'b1;
          ds_wdata = top_rd - sec_rd;
        end
        svm_pkg::OP_XOR: begin
          ds_we    = 1'b1;
          ds_wdata = top_rd ^ sec_rd;
        end
        svm_pkg::OP_MUL_IMM, svm_pkg::OP_MUL: begin
          ds_we    = 1'b1;
          ds_wdata = mul_res;
        end
        default: begin
        end
      endcase
    end

    if (is_call) begin
      if (rc_q == svm_pkg::rc_t'(svm_pkg::CALL_DEPTH)) begin
        fault_d = svm_pkg::FAULT_CALL_OVER;
      end else begin
        rs_we = 1'b1;
        rc_d  = rc_q + svm_pkg::rc_t'(1);
        nip_d = target;
      end
    end
  end

  // Heap write port: zero sweep after reset, else the executing instruction
  assign hp_we    = (state_q == ST_CLEAR) || (advance && hp_exec_we);
  assign hp_waddr = (state_q == ST_CLEAR) ? clr_q : svm_pkg::haddr_t'(hidx_q);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    ip_d    = ip_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + svm_pkg::haddr_t'(1);
        if (clr_q == svm_pkg::haddr_t'(svm_pkg::HEAP_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (advance) begin
          ip_d    = nip_d;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ip_q        <= '0;
      sc_q        <= '0;
      rc_q        <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ip_q    <= ip_d;
      if (advance) begin
        sc_q        <= sc_d;
        rc_q        <= rc_d;
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.operation;
      imm_q  <= in_i.immediate;
      hidx_q <= in_i.heap_index;
    end
    if (advance) begin
      nip_q   <= nip_d;
      ev_q    <= ev_d;
      eb_q    <= eb_d;
      oflag_q <= flag_d;
      fault_q <= fault_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.next_ip      = nip_q;
  assign out_o.emit_valid   = ev_q;
  assign out_o.emit_byte    = eb_q;
  assign out_o.compare_flag = oflag_q;
  assign out_o.fault        = fault_q;

  // Two copies of the data stack give the top and second entries in one read
  svm_ram #(.WIDTH(svm_pkg::IMM_W), .DEPTH(svm_pkg::STACK_DEPTH)) u_ds_top (
    .clk_i   (clk_i),
    .we_i    (advance && ds_we),
    .waddr_i (ds_waddr),
    .wdata_i (ds_wdata),
    .raddr_i (top_addr),
    .rdata_o (top_rd)
  );

  svm_ram #(.WIDTH(svm_pkg::IMM_W), .DEPTH(svm_pkg::STACK_DEPTH)) u_ds_sec (
    .clk_i   (clk_i),
    .we_i    (advance && ds_we),
    .waddr_i (ds_waddr),
    .wdata_i (ds_wdata),
    .raddr_i (sec_addr),
    .rdata_o (sec_rd)
  );

  svm_ram #(.WIDTH(svm_pkg::IP_W), .DEPTH(svm_pkg::CALL_DEPTH)) u_rs (
    .clk_i   (clk_i),
    .we_i    (advance && rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (ip_q + svm_pkg::ip_t'(2)),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rd)
  );

  svm_ram #(.WIDTH(svm_pkg::IMM_W), .DEPTH(svm_pkg::HEAP_DEPTH)) u_heap (
    .clk_i   (clk_i),
    .we_i    (hp_we),
    .waddr_i (hp_waddr),
    .wdata_i ((state_q == ST_CLEAR) ? '0 : hp_wdata),
    .raddr_i (hp_raddr),
    .rdata_o (hp_rd)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("instruction accepted while another executes");

  a_sc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= svm_pkg::sc_t'(svm_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= svm_pkg::rc_t'(svm_pkg::CALL_DEPTH))
    else $error("call count beyond depth");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!in_i.ready && !out_o.valid && !advance))
    else $error("activity during heap sweep");

  a_call_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && fault_d == svm_pkg::FAULT_CALL_OVER) |=> (rc_q == $past(rc_q)))
    else $error("call stack changed on call overflow");

endmodule

/* rtl/svm_ram.sv */
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Bench for the stack machine execute stage. A shadow of the machine state
// predicts one result per accepted instruction; results are compared in
// order as they leave. Directed corner cases come first, then random
// programmes with call bursts, stack fills and trims, under random idling.
// ----------------------------------------------------------------------------
module tb;
  import svm_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct packed {
    ip_t                next_ip;
    logic               emit_valid;
    logic [IMM_W-1:0]   emit_byte;
    logic               flag;
    logic [FAULT_W-1:0] fault;
  } result_t;

  typedef enum int {MODE_MIXED, MODE_CALLS, MODE_FILL, MODE_TRIM} mix_e;

  class machine_shadow;
    bit [IP_W-1:0]  ip;
    bit [IMM_W-1:0] stack [STACK_DEPTH];
    bit             written [STACK_DEPTH];
    int             depth;
    bit [IP_W-1:0]  returns [CALL_DEPTH];
    int             calls;
    bit [IMM_W-1:0] heap [HEAP_DEPTH];
    bit             flag;
    result_t        expected [$];
    int             errors;
    int             checked;
    int             fault_seen [5];

    function int operand_bytes(logic [OP_W-1:0] op);
      case (op_e'(op))
        OP_PUSH, OP_CALL_ABS, OP_ADD_IMM, OP_CMP_IMM, OP_XOR_IMM, OP_JMP, OP_JE, OP_JNE,
        OP_CALL_REL, OP_DROP, OP_RAISE, OP_MUL_IMM: return 1;
        OP_LOAD, OP_HEAP_TOP:                      return 2;
        OP_HEAP_IMM:                               return 3;
        default:                                   return 0;
      endcase
    endfunction

    function int entries_needed(logic [OP_W-1:0] op);
      case (op_e'(op))
        OP_CALL_TOP, OP_ADD_IMM, OP_CMP_IMM, OP_XOR_IMM, OP_EMIT, OP_HEAP_TOP,
        OP_MUL_IMM:                            return 1;
        OP_CMP, OP_ADD, OP_SUB, OP_XOR, OP_MUL: return 2;
        default:                               return 0;
      endcase
    endfunction

    // True when the operation would read a stack slot that raise left unwritten
    function bit reads_undefined(logic [OP_W-1:0] op);
      int n;
      n = entries_needed(op);
      if (depth < n) return 1'b0;
      if (n >= 1 && !written[depth-1]) return 1'b1;
      if (n == 2 && !written[depth-2]) return 1'b1;
      return 1'b0;
    endfunction

    function logic [IMM_W-1:0] top_value(logic [IMM_W-1:0] fallback);
      if (depth > 0 && written[depth-1]) return stack[depth-1];
      return fallback;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void execute(logic [OP_W-1:0] op, logic [IMM_W-1:0] imm,
                          logic [HIDX_W-1:0] hidx);
      result_t r;
      ip_t     nxt;
      ip_t     target;
      int      t;
      int      s;
      bit      is_call;
      bit      in_range;
      nxt          = ip + ip_t'(operand_bytes(op)) + 16'd1;
      r.emit_valid = 1'b0;
      r.emit_byte  = '0;
      r.fault      = FAULT_NONE;
      is_call      = 1'b0;
      target       = '0;
      in_range     = (int'(hidx) < HEAP_DEPTH);
      if (depth < entries_needed(op)) begin
        r.fault = FAULT_UNDER;
      end else begin
        t = (depth > 0) ? depth - 1 : 0;
        s = (depth > 1) ? depth - 2 : 0;
        case (op_e'(op))
          OP_PUSH, OP_LOAD: begin
            if (depth >= STACK_DEPTH) begin
              r.fault = FAULT_OVER;
            end else begin
              if (op == OP_LOAD) stack[depth] = in_range ? heap[hidx] : '0;
              else stack[depth] = imm;
              written[depth] = 1'b1;
              depth++;
            end
          end
          OP_HEAP_IMM: if (in_range) heap[hidx] = imm;
          OP_HEAP_TOP: if (in_range) heap[hidx] = stack[t];
          OP_CALL_TOP: begin
            is_call = 1'b1;
            target  = ip_t'(stack[t]);
          end
          OP_CALL_ABS: begin
            is_call = 1'b1;
            target  = ip_t'(imm);
          end
          OP_CALL_REL: begin
            is_call = 1'b1;
            target  = ip + 16'd2 + ip_t'(imm);
          end
          OP_RET: begin
            if (calls == 0) begin
              r.fault = FAULT_CALL_UNDER;
            end else begin
              calls--;
              nxt = returns[calls];
            end
          end
          OP_ADD_IMM: stack[t] = stack[t] + imm;
          OP_CMP_IMM: flag = (stack[t] == imm);
          OP_XOR_IMM: stack[t] = stack[t] ^ imm;
          OP_JMP:     nxt = ip_t'(imm);
          OP_JE:      if (flag) nxt = ip_t'(imm);
          OP_JNE:     if (!flag) nxt = ip_t'(imm);
          OP_CMP:     flag = (stack[t] == stack[s]);
          OP_EMIT: begin
            r.emit_valid = 1'b1;
            r.emit_byte  = stack[t];
          end
          OP_DROP: begin
            if (int'(imm) > depth) r.fault = FAULT_UNDER;
            else depth -= int'(imm);
          end
          // raised slots keep their old contents
          OP_RAISE: begin
            if (depth + int'(imm) > STACK_DEPTH) r.fault = FAULT_OVER;
            else depth += int'(imm);
          end
          OP_ADD:     stack[t] = stack[t] + stack[s];
          OP_SUB:     stack[t] = stack[t] - stack[s];
          OP_XOR:     stack[t] = stack[t] ^ stack[s];
          OP_MUL_IMM: stack[t] = stack[t] * imm;
          OP_MUL:     stack[t] = stack[t] * stack[s];
          default: ;
        endcase
      end
      if (is_call) begin
        if (calls >= CALL_DEPTH) begin
          r.fault = FAULT_CALL_OVER;
        end else begin
          returns[calls] = ip + 16'd2;
          calls++;
          nxt = target;
        end
      end
      ip        = nxt;
      r.next_ip = nxt;
      r.flag    = flag;
      fault_seen[r.fault]++;
      expected.push_back(r);
    endfunction

    function void compare(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        $display("%0t: result beat with nothing expected: ip %h emit %b/%h flag %b fault %0d",
                 $time, got.next_ip, got.emit_valid, got.emit_byte, got.flag, got.fault);
        errors++;
        return;
      end
      want = expected.pop_front();
      checked++;
      if (got !== want) begin
        $display({"%0t: expected ip %h emit %b/%h flag %b fault %0d,",
                  " got ip %h emit %b/%h flag %b fault %0d"},
                 $time, want.next_ip, want.emit_valid, want.emit_byte, want.flag, want.fault,
                 got.next_ip, got.emit_valid, got.emit_byte, got.flag, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  svm_in_if  in_bus ();
  svm_out_if out_bus ();

  stack_vm_instruction_execute dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  machine_shadow shadow = new();
  mix_e mode = MODE_MIXED;
  bit   calm = 1'b0;
  int   sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic issue(logic [OP_W-1:0] op, logic [IMM_W-1:0] imm,
                       logic [HIDX_W-1:0] hidx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    // never let an unwritten slot be read back
    if (shadow.reads_undefined(op)) op = OP_PUSH;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.immediate  <= imm;
    in_bus.heap_index <= hidx;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    shadow.execute(op, imm, hidx);
    sent++;
  endtask

  // Hold off new beats until every outstanding result has been taken
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() > 0) @(posedge clk_i);
  endtask

  task automatic issue_random();
    logic [OP_W-1:0]   op;
    logic [IMM_W-1:0]  imm;
    logic [HIDX_W-1:0] hidx;
    int                pick;
    op_e               call_ops [3] = '{OP_CALL_TOP, OP_CALL_ABS, OP_CALL_REL};
    pick = $urandom_range(0, 99);
    op   = OP_W'($urandom_range(OP_PUSH, OP_MUL));
    case (mode)
      MODE_CALLS: begin
        if (pick < 70) op = call_ops[$urandom_range(0, 2)];
        else if (pick < 72) op = OP_RET;
      end
      MODE_FILL: begin
        if (pick < 40) op = OP_PUSH;
        else if (pick < 50) op = OP_LOAD;
      end
      MODE_TRIM: begin
        if (pick < 25) op = OP_DROP;
        else if (pick < 35) op = OP_RAISE;
      end
      default: begin
        if (pick < 20) op = OP_PUSH;
        else if (pick < 30) op = OP_RET;
      end
    endcase
    imm = IMM_W'($urandom_range(0, 255));
    if (op == OP_DROP && $urandom_range(0, 3) != 0)
      imm = IMM_W'($urandom_range(0, (shadow.depth < 8) ? shadow.depth : 8));
    else if (op == OP_RAISE && $urandom_range(0, 3) != 0)
      imm = IMM_W'($urandom_range(0, 4));
    else if ((op == OP_CMP_IMM || op == OP_PUSH) && $urandom_range(0, 2) == 0)
      imm = shadow.top_value(imm);
    // keep half the heap traffic on entries 0 to 15 so loads see stored bytes
    hidx = ($urandom_range(0, 1) == 0) ? HIDX_W'($urandom_range(0, 15)) : HIDX_W'($urandom());
    issue(op, imm, hidx);
  endtask

  initial begin : result_sink
    result_t got;
    int      stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      got = {out_bus.next_ip, out_bus.emit_valid, out_bus.emit_byte,
             out_bus.compare_flag, out_bus.fault};
      shadow.compare(got);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= OP_PUSH;
    in_bus.immediate  <= '0;
    in_bus.heap_index <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty machine: guarded operations must fault; then each runs on pushed entries
    issue(OP_RET,      8'h00, '0);
    issue(OP_ADD,      8'h00, '0);
    issue(OP_DROP,     8'h01, '0);
    issue(OP_PUSH,     8'hFF, '0);
    issue(OP_CMP,      8'h00, '0);
    issue(OP_PUSH,     8'h00, '0);
    issue(OP_ADD,      8'h00, '0);
    issue(OP_SUB,      8'h00, '0);
    issue(OP_MUL,      8'h00, '0);
    issue(OP_XOR,      8'h00, '0);
    issue(OP_CMP,      8'h00, '0);
    issue(OP_MUL_IMM,  8'hFF, '0);
    issue(OP_XOR_IMM,  8'hAA, '0);
    issue(OP_ADD_IMM,  8'h80, '0);
    issue(OP_CMP_IMM,  8'h00, '0);
    issue(OP_JE,       8'hFF, '0);
    issue(OP_JNE,      8'h00, '0);
    issue(OP_JMP,      8'hFF, '0);
    issue(OP_HEAP_IMM, 8'h5A, 12'hFFF);
    issue(OP_LOAD,     8'h00, 12'hFFF);
    issue(OP_HEAP_TOP, 8'h00, 12'h000);
    issue(OP_EMIT,     8'h00, '0);
    issue(OP_CALL_ABS, 8'hFF, '0);
    issue(OP_CALL_REL, 8'hFF, '0);
    issue(OP_CALL_TOP, 8'h00, '0);
    issue(OP_RET,      8'h00, '0);
    issue(OP_RET,      8'h00, '0);
    // raise past the top, then fill exactly and push onto the full stack
    issue(OP_RAISE,    8'hFF, '0);
    issue(OP_RAISE,    IMM_W'(STACK_DEPTH - shadow.depth), '0);
    issue(OP_PUSH,     8'h11, '0);
    issue(OP_DROP,     8'hFF, '0);
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        mode = mix_e'($urandom_range(MODE_MIXED, MODE_TRIM));
        calm = ($urandom_range(0, 4) == 0);
      end
      if (n % 400 == 399) drain();
      issue_random();
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("%0d instructions executed, %0d results compared, %0d mismatched",
             sent, shadow.checked, shadow.errors);
    $display("faults: underflow %0d, overflow %0d, call overflow %0d, call underflow %0d",
             shadow.fault_seen[FAULT_UNDER], shadow.fault_seen[FAULT_OVER],
             shadow.fault_seen[FAULT_CALL_OVER], shadow.fault_seen[FAULT_CALL_UNDER]);
    if (shadow.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
rtl/svm_pkg.sv
rtl/svm_in_if.sv
rtl/svm_out_if.sv
rtl/svm_ram.sv
rtl/stack_vm_instruction_execute.sv
bench/tb.sv
